[rtl/sdiv_pkg.sv]
`default_nettype none

package sdiv_pkg;

  // Fixed width of the operand and quotient ports
  localparam int unsigned DATA_W = 64;

  // Default internal division width
  localparam int unsigned DIV_WIDTH = 64;

  // Control that travels with each pipeline transaction
  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/signed_restoring_divider.sv]
// Pipeline from the start edge to the out_valid cycle:
//   one operand magnitude stage, one restoring step stage per quotient bit, one sign stage.
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// Reset (rst_n low, synchronous) clears the valid bits of every stage; data is not reset.
`default_nettype none

module signed_restoring_divider
  import sdiv_pkg::*;
#(
  parameter int unsigned WIDTH = DIV_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [DATA_W-1:0] in_dividend,
  input  wire logic [DATA_W-1:0] in_divisor,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_quotient
);

  ctl_t             ctl_a [0:WIDTH];
  logic [WIDTH-1:0] num_a [0:WIDTH];
  logic [WIDTH-1:0] den_a [0:WIDTH];
  logic [WIDTH-1:0] rem_a [0:WIDTH];
  logic [WIDTH-1:0] quo_a [0:WIDTH];

  // The pipeline takes a transaction every cycle
  assign busy = 1'b0;

  // Take magnitudes and the result sign
  sdiv_prep #(
    .WIDTH (WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dividend (in_dividend),
    .divisor  (in_divisor),
    .ctl_o    (ctl_a[0]),
    .num_o    (num_a[0]),
    .den_o    (den_a[0])
  );

  // Remainder and quotient start at zero
  assign rem_a[0] = '0;
  assign quo_a[0] = '0;

  // One restoring step per quotient bit, most significant first
  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    sdiv_step #(
      .WIDTH (WIDTH),
      .BIT   (WIDTH - 1 - k)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_a[k]),
      .num_i (num_a[k]),
      .den_i (den_a[k]),
      .rem_i (rem_a[k]),
      .quo_i (quo_a[k]),
      .ctl_o (ctl_a[k+1]),
      .num_o (num_a[k+1]),
      .den_o (den_a[k+1]),
      .rem_o (rem_a[k+1]),
      .quo_o (quo_a[k+1])
    );
  end

  // Negate and sign-extend
  sdiv_post #(
    .WIDTH (WIDTH)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl_a[WIDTH]),
    .quo_i      (quo_a[WIDTH]),
    .valid_o    (out_valid),
    .quotient_o (out_quotient)
  );

  // Final remainder stays below a nonzero divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_a[WIDTH].valid && (den_a[WIDTH] != '0)) |-> (rem_a[WIDTH] < den_a[WIDTH]))
    else $error("remainder not below divisor");

  // Division by zero yields an all-ones magnitude
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_a[WIDTH].valid && (den_a[WIDTH] == '0)) |-> (&quo_a[WIDTH]))
    else $error("divide by zero magnitude not all ones");

  // The divisor magnitude never exceeds the most negative value's magnitude
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_a[0].valid && den_a[0][WIDTH-1]) |-> (den_a[0][WIDTH-2:0] == '0))
    else $error("divisor magnitude out of range");

  // A finished step stage always reaches the output next cycle
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_a[WIDTH].valid |=> out_valid)
    else $error("result strobe lost");

endmodule

`default_nettype wire

[rtl/sdiv_prep.sv]
`default_nettype none

module sdiv_prep
  import sdiv_pkg::*;
#(
  parameter int unsigned WIDTH = DIV_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output ctl_t                   ctl_o,
  output logic [WIDTH-1:0]       num_o,
  output logic [WIDTH-1:0]       den_o
);

  logic [WIDTH-1:0] num_raw;
  logic [WIDTH-1:0] den_raw;
  logic [WIDTH-1:0] num_mag;
  logic [WIDTH-1:0] den_mag;
  ctl_t             ctl_r;
  logic [WIDTH-1:0] num_r;
  logic [WIDTH-1:0] den_r;

  // Keep the low WIDTH bits and take unsigned magnitudes
  always_comb begin
    num_raw = dividend[WIDTH-1:0];
    den_raw = divisor[WIDTH-1:0];
    num_mag = num_raw[WIDTH-1] ? (~num_raw + 1'b1) : num_raw;
    den_mag = den_raw[WIDTH-1] ? (~den_raw + 1'b1) : den_raw;
  end

  // Advance control; valid clears on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= start;
      ctl_r.neg   <= num_raw[WIDTH-1] ^ den_raw[WIDTH-1];
    end
  end

  // Hold operand magnitudes
  always_ff @(posedge clk) begin
    num_r <= num_mag;
    den_r <= den_mag;
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;
  assign den_o = den_r;

endmodule

`default_nettype wire

[rtl/sdiv_step.sv]
`default_nettype none

module sdiv_step
  import sdiv_pkg::*;
#(
  parameter int unsigned WIDTH = DIV_WIDTH,
  parameter int unsigned BIT   = DIV_WIDTH - 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctl_t             ctl_i,
  input  wire logic [WIDTH-1:0] num_i,
  input  wire logic [WIDTH-1:0] den_i,
  input  wire logic [WIDTH-1:0] rem_i,
  input  wire logic [WIDTH-1:0] quo_i,
  output ctl_t                  ctl_o,
  output logic [WIDTH-1:0]      num_o,
  output logic [WIDTH-1:0]      den_o,
  output logic [WIDTH-1:0]      rem_o,
  output logic [WIDTH-1:0]      quo_o
);

  logic [WIDTH-1:0] rem_shift;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0] quo_nxt;
  ctl_t             ctl_r;
  logic [WIDTH-1:0] num_r;
  logic [WIDTH-1:0] den_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] quo_r;

  // Shift in one dividend bit, trial subtract, restore on borrow
  always_comb begin
    rem_shift    = {rem_i[WIDTH-2:0], num_i[BIT]};
    diff         = {1'b0, rem_shift} - {1'b0, den_i};
    ge           = ~diff[WIDTH];
    rem_nxt      = ge ? diff[WIDTH-1:0] : rem_shift;
    quo_nxt      = quo_i;
    quo_nxt[BIT] = ge;
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    num_r <= num_i;
    den_r <= den_i;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

`default_nettype wire

[rtl/sdiv_post.sv]
`default_nettype none

module sdiv_post
  import sdiv_pkg::*;
#(
  parameter int unsigned WIDTH = DIV_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctl_t             ctl_i,
  input  wire logic [WIDTH-1:0] quo_i,
  output logic                  valid_o,
  output logic [DATA_W-1:0]     quotient_o
);

  logic signed [WIDTH-1:0] quo_signed;
  logic                    valid_r;
  logic [DATA_W-1:0]       quotient_r;

  // Apply the sign; a wrap of the most negative value is intended
  assign quo_signed = ctl_i.neg ? signed'(~quo_i + 1'b1) : signed'(quo_i);

  // Drive the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  // Sign-extend to the port width
  always_ff @(posedge clk) begin
    quotient_r <= DATA_W'(quo_signed);
  end

  assign valid_o    = valid_r;
  assign quotient_o = quotient_r;

endmodule

`default_nettype wire

[dv/signed_restoring_divider_tb.sv]
module signed_restoring_divider_tb
  import sdiv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MINUS_ONE = '1;

  // Shapes of random operands
  typedef enum int unsigned {
    SHAPE_FULL,
    SHAPE_SMALL,
    SHAPE_NARROW,
    SHAPE_EDGE,
    SHAPE_POW2,
    SHAPE_COUNT
  } operand_shape_e;

  // Quotient predictor and in-order store of expected quotients
  class quotient_scoreboard;
    logic [DATA_W-1:0] expected_quotients[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function logic [DATA_W-1:0] predict_quotient(logic [DATA_W-1:0] dividend,
                                                 logic [DATA_W-1:0] divisor);
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] sign;
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] quo;
      bit flip;
      mask = (DIV_WIDTH >= DATA_W) ? '1 : ((64'd1 << DIV_WIDTH) - 64'd1);
      sign = 64'd1 << (DIV_WIDTH - 1);
      flip = 1'b0;
      // Reduce both operands to unsigned magnitudes, track the sign
      num = dividend & mask;
      if ((num & sign) != 0) begin
        flip = !flip;
        num = (-num) & mask;
      end
      den = divisor & mask;
      if ((den & sign) != 0) begin
        flip = !flip;
        den = (-den) & mask;
      end
      // Restoring division, one quotient bit per step from the top
      rem = '0;
      quo = '0;
      for (int i = DIV_WIDTH - 1; i >= 0; i--) begin
        rem = ((rem << 1) | ((num >> i) & 64'd1)) & mask;
        if (rem >= den) begin
          rem = rem - den;
          quo[i] = 1'b1;
        end
      end
      if (flip) quo = -quo;
      quo = quo & mask;
      if ((quo & sign) != 0) quo = quo | ~mask;
      return quo;
    endfunction

    function void note_division(logic [DATA_W-1:0] dividend, logic [DATA_W-1:0] divisor);
      expected_quotients.push_back(predict_quotient(dividend, divisor));
    endfunction

    function void check_quotient(logic [DATA_W-1:0] actual);
      logic [DATA_W-1:0] expected;
      if (expected_quotients.size() == 0) begin
        $error("quotient: unexpected transaction, actual %h", actual);
        failures++;
        return;
      end
      expected = expected_quotients.pop_front();
      if (actual !== expected) begin
        $error("quotient mismatch: expected %h, actual %h", expected, actual);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_quotients.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [DATA_W-1:0] in_dividend = '0;
  logic [DATA_W-1:0] in_divisor = '0;
  logic out_valid;
  logic [DATA_W-1:0] out_quotient;

  int unsigned cycle_count = 0;
  bit steady_phase = 1'b0;
  quotient_scoreboard sb = new();

  signed_restoring_divider #(.WIDTH(DIV_WIDTH)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_dividend  (in_dividend),
    .in_divisor   (in_divisor),
    .out_valid    (out_valid),
    .out_quotient (out_quotient)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Record accepted divisions and check every strobed quotient
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_quotient(out_quotient);
      if (start && !busy) sb.note_division(in_dividend, in_divisor);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [DATA_W-1:0] random_operand();
    operand_shape_e shape;
    logic [DATA_W-1:0] value;
    shape = operand_shape_e'($urandom_range(0, SHAPE_COUNT - 1));
    case (shape)
      SHAPE_SMALL: begin
        value = DATA_W'($signed($urandom_range(0, 40)) - 20);
      end
      SHAPE_NARROW: begin
        value = $signed(random_word()) >>> $urandom_range(0, DATA_W - 1);
      end
      SHAPE_EDGE: begin
        case ($urandom_range(0, 4))
          0: value = '0;
          1: value = 64'd1;
          2: value = MINUS_ONE;
          3: value = MOST_NEG;
          default: value = MOST_POS;
        endcase
      end
      SHAPE_POW2: begin
        value = 64'd1 << $urandom_range(0, DATA_W - 1);
        if ($urandom_range(0, 1) != 0) value = -value;
      end
      default: begin
        value = random_word();
      end
    endcase
    return value;
  endfunction

  // Present one division and hold it until the block takes it
  task automatic send_division(input logic [DATA_W-1:0] dividend,
                               input logic [DATA_W-1:0] divisor);
    in_dividend <= dividend;
    in_divisor <= divisor;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Outside the steady phase, now and then drop start and drive noise on the operands
  task automatic idle_maybe();
    if (!steady_phase && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      in_dividend <= random_word();
      in_divisor <= random_word();
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Hold off until every expected quotient has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  logic [DATA_W-1:0] directed_pairs[][2];

  initial begin
    directed_pairs = '{
      '{MOST_POS, MOST_POS}, '{MOST_POS, 64'd1}, '{MOST_POS, MINUS_ONE},
      '{MOST_NEG, MINUS_ONE}, '{MOST_NEG, 64'd1}, '{MOST_NEG, MOST_NEG},
      '{MOST_NEG, MOST_POS}, '{MOST_POS, MOST_NEG}, '{64'd0, 64'd0},
      '{64'd5, 64'd0}, '{-64'd5, 64'd0}, '{MOST_NEG, 64'd0},
      '{MOST_POS, 64'd0}, '{64'd0, MOST_NEG}, '{64'd7, -64'd2},
      '{-64'd7, 64'd2}, '{-64'd7, -64'd2}, '{64'd7, 64'd2},
      '{64'd1, MOST_POS}, '{MINUS_ONE, MOST_NEG}, '{MOST_NEG, 64'd2},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}
    };

    // Hold reset, then release at a falling edge
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners
    foreach (directed_pairs[i]) begin
      idle_maybe();
      send_division(directed_pairs[i][0], directed_pairs[i][1]);
    end

    // Random operands with a back-to-back stretch and one full drain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_phase = (n >= 700 && n < 1000);
      if (n == 1300) wait_for_drain();
      idle_maybe();
      send_division(random_operand(), random_operand());
    end

    // Drain the pipeline and watch for stray strobes
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (DIV_WIDTH + 8) @(negedge clk);

    if (sb.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
